// ===== rtl/core/tdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

  // Width of the number and factor fields on the stream ports.
  localparam int unsigned NUM_W = 31;
  // Stream data width, rounded up to whole bytes.
  localparam int unsigned TDATA_W = 32;
  // Most results one input can produce.
  localparam int unsigned MAX_RESULTS = 31;
  // Width of the per-run factor counter.
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

endpackage

`default_nettype wire

// ===== rtl/core/tdf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdf_div #(
  parameter int unsigned W = 31
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  part_q;
  logic [W-1:0]  quot_q;
  logic [W-1:0]  dvsr_q;
  logic [W:0]    diff;
  logic          ge;

  // One quotient bit per cycle: restoring division, dividend bits leave
  // the top of the shift register while quotient bits enter at the bottom.
  assign diff = {part_q, quot_q[W-1]} - {1'b0, dvsr_q};
  assign ge   = ~diff[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      part_q <= '0;
      quot_q <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      part_q <= ge ? diff[W-1:0] : {part_q[W-2:0], quot_q[W-1]};
      quot_q <= {quot_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = part_q;

endmodule

`default_nettype wire

// ===== rtl/core/trial_division_factorizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each trial divisor passes through ST_START, which loads the bit-serial divider, ST_WAIT,
// which waits while it forms VALUE_BITS quotient bits and sees it finish, and ST_EVAL,
// which judges the result. A 31-bit prime needs about 23200 trials.
// One input is worked on at a time. Each result beat leaves through an output register;
// a factor found is held back until the next result shows whether it is the last.
// Reset is asynchronous and active low; it empties the block, which then waits idle.

module trial_division_factorizer #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: number (31 bits), zero fill (1 bit).
  input  wire logic [tdf_pkg::TDATA_W-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // Fields from bit 0: factor (31 bits), zero fill (1 bit).
  output logic [tdf_pkg::TDATA_W-1:0]       m_axis_tdata_o,
  // Fields from bit 0: has_factor (1 bit).
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  import tdf_pkg::*;

  localparam int unsigned W = VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EVAL,
    ST_END
  } state_e;

  state_e           state_q, state_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     trial_q, trial_d;
  logic [W-1:0]     pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic [NUM_W-1:0] out_fac_q, out_fac_d;
  logic             out_has_q, out_has_d;
  logic             out_last_q, out_last_d;

  logic             div_start;
  logic             div_done;
  logic [W-1:0]     div_quot;
  logic [W-1:0]     div_rem;

  logic [W+NUM_W-1:0] num_ext;
  logic [W+NUM_W-1:0] pend_ext;
  logic [W+NUM_W-1:0] rem_ext;
  logic [W-1:0]       num_in;
  logic               slot_free;
  logic               rem_big;
  logic               out_wr;

  assign num_ext  = {{W{1'b0}}, s_axis_tdata_i[NUM_W-1:0]};
  assign num_in   = num_ext[W-1:0];
  assign pend_ext = {{NUM_W{1'b0}}, pend_q};
  assign rem_ext  = {{NUM_W{1'b0}}, rem_q};

  assign slot_free = !out_vld_q || m_axis_tready_i;
  assign rem_big   = (rem_q[W-1:1] != '0);
  assign div_start = (state_q == ST_START);

  tdf_div #(
    .W(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rem_q),
    .divisor_i (trial_q),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d    = state_q;
    rem_d      = rem_q;
    trial_d    = trial_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    cnt_d      = cnt_q;
    out_wr     = 1'b0;
    out_fac_d  = out_fac_q;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          rem_d      = num_in;
          trial_d    = W'(2);
          pend_vld_d = 1'b0;
          cnt_d      = '0;
          state_d    = (num_in[W-1:1] != '0) ? ST_START : ST_END;
        end
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if ((cnt_q >= CNT_W'(MAX_RESULTS - 1)) || (trial_q > div_quot)) begin
          state_d = ST_END;
        end else if (div_rem == '0) begin
          // A factor found; the one held before it is now known not to be last.
          if (!pend_vld_q || slot_free) begin
            if (pend_vld_q) begin
              out_wr     = 1'b1;
              out_fac_d  = pend_ext[NUM_W-1:0];
              out_has_d  = 1'b1;
              out_last_d = 1'b0;
            end
            pend_d     = trial_q;
            pend_vld_d = 1'b1;
            cnt_d      = cnt_q + CNT_W'(1);
            rem_d      = div_quot;
            state_d    = ST_START;
          end
        end else begin
          trial_d = (trial_q == W'(2)) ? W'(3) : trial_q + W'(2);
          state_d = ST_START;
        end
      end
      ST_END: begin
        if (slot_free) begin
          out_wr = 1'b1;
          if (pend_vld_q) begin
            out_fac_d  = pend_ext[NUM_W-1:0];
            out_has_d  = 1'b1;
            out_last_d = !rem_big;
            pend_vld_d = 1'b0;
            state_d    = rem_big ? ST_END : ST_IDLE;
          end else begin
            out_fac_d  = rem_big ? rem_ext[NUM_W-1:0] : '0;
            out_has_d  = rem_big;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_vld_d = out_wr ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    trial_q    <= trial_d;
    pend_q     <= pend_d;
    out_fac_q  <= out_fac_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(TDATA_W - NUM_W){1'b0}}, out_fac_q};
  assign m_axis_tuser_o  = out_has_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid_i,
  input wire logic                        s_axis_tready_o,
  input wire logic [tdf_pkg::TDATA_W-1:0] s_axis_tdata_i,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [tdf_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                        m_axis_tuser_o,
  input wire logic                        m_axis_tlast_o
);

  import tdf_pkg::*;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result beat changed");

  // A beat without a factor closes its run and carries zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("beat without factor is malformed");

  // Taking a number drops the input ready, so no further number is taken straight after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a run is in progress");

  // A result beat is never shown without a run having started.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o) || $past(m_axis_tvalid_o))
    else $error("result beat appeared while idle");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (.*);

`default_nettype wire
